@@ sv/ctrp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctrp_pkg
// Shared types, character codes and fixed-point helpers for the trade record
// parser.
// ----------------------------------------------------------------------------
package ctrp_pkg;

	localparam int MAX_POW = 18;

	typedef enum logic [2:0] {
		ST_RECORD   = 3'd0,
		ST_COMMA    = 3'd1,
		ST_SIDE     = 3'd2,
		ST_NEWLINE  = 3'd3,
		ST_EOI_SIDE = 3'd4
	} status_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [63:0]        order_id;
		logic signed [63:0] price_scaled;
		logic [63:0]        quantity_scaled;
		logic [63:0]        event_time;
		logic               sell_side;
	} result_t;

	localparam logic REQ_DATA = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_T_LC  = 8'h74;
	localparam logic [7:0] CH_T_UC  = 8'h54;
	localparam logic [7:0] CH_F_LC  = 8'h66;
	localparam logic [7:0] CH_F_UC  = 8'h46;

	// 10^n for n <= MAX_POW, only ever called with elaboration-time arguments
	function automatic logic [63:0] pow10(input int n);
		logic [63:0] r;
		r = 64'd1;
		for (int i = 0; i < MAX_POW; i++) begin
			if (i < n) begin
				r = r * 64'd10;
			end
		end
		return r;
	endfunction

	// digit 0..9 times a 64-bit weight, as shift-add
	function automatic logic [63:0] mul_digit(input logic [3:0] d, input logic [63:0] m);
		logic [63:0] r;
		r = 64'd0;
		if (d[0]) r = r + m;
		if (d[1]) r = r + (m << 1);
		if (d[2]) r = r + (m << 2);
		if (d[3]) r = r + (m << 3);
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/ctrp_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ctrp_core
// Column tracker and running scaled accumulators; consumes one beat per step
// and produces at most one result in the same cycle.
// ----------------------------------------------------------------------------
module ctrp_core
	import ctrp_pkg::*;
#(
	parameter int FRAC_DIGITS = 8
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire item_t   item,
	output logic         res_valid,
	output result_t      res
);

	localparam int CW = $clog2(FRAC_DIGITS + 1);

	typedef enum logic [6:0] {
		COL_ID    = 7'b0000001,
		COL_PRICE = 7'b0000010,
		COL_QTY   = 7'b0000100,
		COL_SKIP  = 7'b0001000,
		COL_TIME  = 7'b0010000,
		COL_SIDE  = 7'b0100000,
		COL_EXTRA = 7'b1000000
	} col_t;

	col_t            col_q, col_nxt;
	logic            line_started_q, line_started_nxt;
	logic            in_frac_q, in_frac_nxt;
	logic [CW-1:0]   frac_cnt_q, frac_cnt_nxt;
	logic            side_seen_q, side_seen_nxt;
	logic            cr_seen_q, cr_seen_nxt;
	logic            halted_q, halted_nxt;
	logic [63:0]     id_q, id_nxt;
	logic [63:0]     price_q, price_nxt;
	logic [63:0]     qty_q, qty_nxt;
	logic [63:0]     time_q, time_nxt;
	logic            side_q, side_nxt;

	logic [63:0]     pow10_tbl [FRAC_DIGITS+1];
	logic [7:0]      b;
	logic            is_digit, is_eol, is_comma, frac_room;
	logic [CW-1:0]   frac_idx;
	logic [63:0]     acc_sel, weight, base, acc_sum;
	logic            give_rec, give_err;
	status_t         err_code;

	for (genvar g = 0; g <= FRAC_DIGITS; g++) begin : g_pow
		assign pow10_tbl[g] = pow10(g);
	end

	assign b         = item.data_byte;
	assign is_digit  = (b >= CH_0) && (b <= CH_9);
	assign is_eol    = (b == CH_CR) || (b == CH_LF);
	assign is_comma  = (b == CH_COMMA);
	assign frac_room = frac_cnt_q < CW'(FRAC_DIGITS);
	assign frac_idx  = CW'(FRAC_DIGITS - 1) - frac_cnt_q;

	// one shared multiply-by-ten-and-add for whichever numeric column is open,
	// add only in a fraction; price and quantity stay scaled by 10^FRAC_DIGITS
	always_comb begin
		unique case (col_q)
			COL_ID:    acc_sel = id_q;
			COL_PRICE: acc_sel = price_q;
			COL_QTY:   acc_sel = qty_q;
			COL_TIME:  acc_sel = time_q;
			default:   acc_sel = 64'd0;
		endcase
		if ((col_q == COL_PRICE) || (col_q == COL_QTY)) begin
			weight = in_frac_q ? pow10_tbl[frac_idx] : pow10_tbl[FRAC_DIGITS];
		end else begin
			weight = 64'd1;
		end
		base    = (in_frac_q) ? acc_sel : ((acc_sel << 3) + (acc_sel << 1));
		acc_sum = base + mul_digit(b[3:0], weight);
	end

	always_comb begin
		col_nxt          = col_q;
		line_started_nxt = line_started_q;
		in_frac_nxt      = in_frac_q;
		frac_cnt_nxt     = frac_cnt_q;
		side_seen_nxt    = side_seen_q;
		cr_seen_nxt      = cr_seen_q;
		halted_nxt       = halted_q;
		id_nxt           = id_q;
		price_nxt        = price_q;
		qty_nxt          = qty_q;
		time_nxt         = time_q;
		side_nxt         = side_q;
		give_rec         = 1'b0;
		give_err         = 1'b0;
		err_code         = ST_COMMA;

		if (item.req_type == REQ_END) begin
			if (!halted_q && line_started_q) begin
				if (col_q == COL_EXTRA) begin
					give_rec = 1'b1;
				end else begin
					give_err = 1'b1;
					err_code = (col_q == COL_SIDE && !side_seen_q) ? ST_EOI_SIDE : ST_COMMA;
				end
			end
		end else if (!halted_q && (line_started_q || !is_eol)) begin
			line_started_nxt = 1'b1;
			unique case (col_q)
				COL_ID, COL_TIME: begin
					if (is_digit) begin
						if (col_q == COL_ID) id_nxt = acc_sum;
						else                 time_nxt = acc_sum;
					end else if (is_comma) begin
						col_nxt = (col_q == COL_ID) ? COL_PRICE : COL_SIDE;
					end else begin
						give_err = 1'b1;
					end
				end
				COL_PRICE, COL_QTY: begin
					if (is_digit) begin
						if (!in_frac_q || frac_room) begin
							if (col_q == COL_PRICE) price_nxt = acc_sum;
							else                    qty_nxt = acc_sum;
						end
						if (in_frac_q && frac_room) frac_cnt_nxt = frac_cnt_q + CW'(1);
					end else if (b == CH_DOT && !in_frac_q) begin
						in_frac_nxt = 1'b1;
					end else if (is_comma) begin
						in_frac_nxt  = 1'b0;
						frac_cnt_nxt = '0;
						col_nxt      = (col_q == COL_PRICE) ? COL_QTY : COL_SKIP;
					end else begin
						give_err = 1'b1;
					end
				end
				COL_SKIP: begin
					if (is_comma) col_nxt = COL_TIME;
					else if (is_eol) give_err = 1'b1;
				end
				COL_SIDE: begin
					if (!side_seen_q) begin
						side_seen_nxt = 1'b1;
						if (b == CH_T_LC || b == CH_T_UC || b == CH_1) begin
							side_nxt = 1'b1;
						end else if (b == CH_F_LC || b == CH_F_UC || b == CH_0) begin
							side_nxt = 1'b0;
						end else begin
							give_err = 1'b1;
							err_code = ST_SIDE;
						end
					end else if (is_comma) begin
						col_nxt = COL_EXTRA;
					end else if (is_eol) begin
						give_err = 1'b1;
					end
				end
				COL_EXTRA: begin
					if (b == CH_LF) begin
						give_rec = 1'b1;
					end else if (cr_seen_q || is_comma) begin
						give_err = 1'b1;
						err_code = ST_NEWLINE;
					end else if (b == CH_CR) begin
						cr_seen_nxt = 1'b1;
					end
				end
				default: begin
					give_err = 1'b1;
				end
			endcase
		end

		res_valid = give_rec || give_err;
		res       = '0;
		if (give_rec) begin
			res.status          = ST_RECORD;
			res.order_id        = id_q;
			res.price_scaled    = $signed(price_q);
			res.quantity_scaled = qty_q;
			res.event_time      = time_q;
			res.sell_side       = side_q;
		end else if (give_err) begin
			res.status = err_code;
			halted_nxt = 1'b1;
		end

		// a finished record, or end of input, drops back to the first column
		if (give_rec || item.req_type == REQ_END) begin
			col_nxt          = COL_ID;
			line_started_nxt = 1'b0;
			in_frac_nxt      = 1'b0;
			frac_cnt_nxt     = '0;
			side_seen_nxt    = 1'b0;
			cr_seen_nxt      = 1'b0;
			id_nxt           = 64'd0;
			price_nxt        = 64'd0;
			qty_nxt          = 64'd0;
			time_nxt         = 64'd0;
			side_nxt         = 1'b0;
		end
		if (item.req_type == REQ_END) begin
			halted_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q          <= COL_ID;
			line_started_q <= 1'b0;
			in_frac_q      <= 1'b0;
			frac_cnt_q     <= '0;
			side_seen_q    <= 1'b0;
			cr_seen_q      <= 1'b0;
			halted_q       <= 1'b0;
			id_q           <= 64'd0;
			price_q        <= 64'd0;
			qty_q          <= 64'd0;
			time_q         <= 64'd0;
			side_q         <= 1'b0;
		end else if (step) begin
			col_q          <= col_nxt;
			line_started_q <= line_started_nxt;
			in_frac_q      <= in_frac_nxt;
			frac_cnt_q     <= frac_cnt_nxt;
			side_seen_q    <= side_seen_nxt;
			cr_seen_q      <= cr_seen_nxt;
			halted_q       <= halted_nxt;
			id_q           <= id_nxt;
			price_q        <= price_nxt;
			qty_q          <= qty_nxt;
			time_q         <= time_nxt;
			side_q         <= side_nxt;
		end
	end

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(step && halted_q && item.req_type == REQ_DATA) |-> !res_valid)
		else $error("result produced while halted on error");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.req_type == REQ_END) |=> (col_q == COL_ID && !line_started_q && !halted_q))
		else $error("end of input did not return parser to idle");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res.status != ST_RECORD && item.req_type == REQ_DATA) |=> halted_q)
		else $error("error result without halting");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frac_q |-> (frac_cnt_q == '0))
		else $error("fraction digit count outside a fraction");

endmodule
`default_nettype wire

@@ sv/csv_trade_record_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csv_trade_record_parser
// Streaming seven-column trade CSV parser, one character beat per clock unless stalled.
//
// Input channel item_valid/item_ready carries one character (req_type 0) or
// an end-of-input marker (req_type 1). Output channel result_valid/
// result_ready carries one parsed record or one error status.
// Throughput: one input beat per cycle, sustained, as long as results are
// taken. An accepted beat sits in the input register; its result, if any,
// goes to the result register when the core steps on it. Per byte, the open
// column's accumulator gets a multiply-by-ten-and-add (in a fraction, an add
// of digit times weight), done combinationally between the registers.
// Reset clears all column state, the accumulators and the valid flags of
// both registers.
// When the receiver stalls, the result register holds; the input register
// holds one more beat, and then item_ready drops until the result is taken.
// After an error, bytes are swallowed until an end-of-input beat.
// ----------------------------------------------------------------------------
module csv_trade_record_parser
	import ctrp_pkg::*;
#(
	parameter int FRAC_DIGITS = 8
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	item_t   item_s1;
	logic    item_valid_s1;
	logic    result_valid_q;
	result_t result_q;
	logic    step;
	logic    core_valid;
	result_t core_res;

	assign step       = item_valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !item_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	ctrp_core #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.res_valid(core_valid),
		.res      (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step) begin
			result_valid_q <= core_valid;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_valid) begin
			result_q <= core_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> (!result_valid_q || result_ready))
		else $error("result register overwritten while stalled");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (item_valid_s1 && result_valid_q && !result_ready))
		else $error("input stalled without a full pipeline");

	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(step && core_valid) |=> result_valid_q)
		else $error("parsed result lost");

endmodule
`default_nettype wire

@@ tb/csv_trade_record_parser_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_trade_record_parser_test
// Feeds CSV characters and end-of-input beats into the trade record parser.
// It parses the same stream in the testbench and compares every record and
// error status with the one the block emits. A short run of hand-written
// lines comes first. Random lines follow, some of them corrupted or cut
// short, under three patterns of idle cycles on both channels and one long
// result stall.
// ----------------------------------------------------------------------------
module csv_trade_record_parser_test;
	import ctrp_pkg::*;

	localparam int FRAC_DIGITS = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 500;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   char_beat = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t parsed;

	item_t       pending_beats[$];
	result_t     expected_records[$];
	logic [7:0]  line_buf[$];
	int unsigned beats_queued = 0;
	int unsigned bad_records = 0;
	int unsigned send_idle_pct = 32;
	int unsigned recv_idle_pct = 81;
	logic        hold_armed = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_cycles = 0;

	// parser state mirrored in the testbench
	logic [2:0]  col;
	bit          line_open, in_frac, side_seen, cr_seen, halted, side_val;
	int unsigned frac_cnt;
	logic [63:0] id_acc, price_acc, qty_acc, time_acc;

	csv_trade_record_parser #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(char_beat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(parsed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_line();
		col = 3'd0;
		line_open = 0;
		in_frac = 0;
		frac_cnt = 0;
		side_seen = 0;
		cr_seen = 0;
		side_val = 0;
		id_acc = '0;
		price_acc = '0;
		qty_acc = '0;
		time_acc = '0;
	endfunction

	function automatic void emit_record();
		result_t r;
		r = '0;
		r.status = ST_RECORD;
		r.order_id = id_acc;
		r.price_scaled = price_acc;
		r.quantity_scaled = qty_acc;
		r.event_time = time_acc;
		r.sell_side = side_val;
		expected_records.push_back(r);
		clear_line();
	endfunction

	function automatic void emit_error(status_t code);
		result_t r;
		r = '0;
		r.status = code;
		expected_records.push_back(r);
		halted = 1;
	endfunction

	function automatic void parse_char(item_t it);
		logic [7:0]  ch;
		logic [63:0] acc;
		bit          digit, eol, advance;
		ch = it.data_byte;
		digit = (ch >= CH_0) && (ch <= CH_9);
		eol = (ch == CH_CR) || (ch == CH_LF);
		if (it.req_type == REQ_END) begin
			if (!halted && line_open) begin
				if (col == 3'd6) begin
					emit_record();
				end else if (col == 3'd5 && !side_seen) begin
					emit_error(ST_EOI_SIDE);
				end else begin
					emit_error(ST_COMMA);
				end
			end
			clear_line();
			halted = 0;
			return;
		end
		if (halted) return;
		if (!line_open) begin
			if (eol) return;
			line_open = 1;
		end
		case (col)
			3'd0, 3'd4: begin
				if (digit) begin
					if (col == 3'd0) id_acc = id_acc * 64'd10 + 64'(ch - CH_0);
					else time_acc = time_acc * 64'd10 + 64'(ch - CH_0);
				end else if (ch == CH_COMMA) begin
					col = col + 3'd1;
				end else begin
					emit_error(ST_COMMA);
				end
			end
			3'd1, 3'd2: begin
				acc = (col == 3'd1) ? price_acc : qty_acc;
				advance = 0;
				if (digit) begin
					// fraction digits past the kept precision are dropped
					if (!in_frac || frac_cnt < FRAC_DIGITS) begin
						acc = acc * 64'd10 + 64'(ch - CH_0);
						if (in_frac) frac_cnt++;
					end
				end else if (ch == CH_DOT && !in_frac) begin
					in_frac = 1;
				end else if (ch == CH_COMMA) begin
					for (int i = frac_cnt; i < FRAC_DIGITS; i++) acc = acc * 64'd10;
					in_frac = 0;
					frac_cnt = 0;
					advance = 1;
				end else begin
					emit_error(ST_COMMA);
					return;
				end
				if (col == 3'd1) price_acc = acc;
				else qty_acc = acc;
				if (advance) col = col + 3'd1;
			end
			3'd3: begin
				if (ch == CH_COMMA) col = 3'd4;
				else if (eol) emit_error(ST_COMMA);
			end
			3'd5: begin
				if (!side_seen) begin
					if (ch == CH_T_LC || ch == CH_T_UC || ch == CH_1) begin
						side_val = 1;
					end else if (ch == CH_F_LC || ch == CH_F_UC || ch == CH_0) begin
						side_val = 0;
					end else begin
						emit_error(ST_SIDE);
						return;
					end
					side_seen = 1;
				end else if (ch == CH_COMMA) begin
					col = 3'd6;
				end else if (eol) begin
					emit_error(ST_COMMA);
				end
			end
			default: begin
				if (cr_seen) begin
					if (ch == CH_LF) emit_record();
					else emit_error(ST_NEWLINE);
				end else if (ch == CH_LF) begin
					emit_record();
				end else if (ch == CH_CR) begin
					cr_seen = 1;
				end else if (ch == CH_COMMA) begin
					emit_error(ST_NEWLINE);
				end
			end
		endcase
	endfunction

	function automatic void check_record(result_t got);
		result_t want;
		if (expected_records.size() == 0) begin
			bad_records++;
			if (bad_records <= 10)
				$display("unexpected result: status %0d id %0h", got.status, got.order_id);
			return;
		end
		want = expected_records.pop_front();
		if (got.status !== want.status || got.order_id !== want.order_id ||
				got.price_scaled !== want.price_scaled ||
				got.quantity_scaled !== want.quantity_scaled ||
				got.event_time !== want.event_time || got.sell_side !== want.sell_side) begin
			bad_records++;
			if (bad_records <= 10) begin
				$display("mismatch expected: status %0d id %0h price %0h qty %0h time %0h sell %0b",
					want.status, want.order_id, want.price_scaled, want.quantity_scaled,
					want.event_time, want.sell_side);
				$display("         actual:   status %0d id %0h price %0h qty %0h time %0h sell %0b",
					got.status, got.order_id, got.price_scaled, got.quantity_scaled,
					got.event_time, got.sell_side);
			end
		end
	endfunction

	function automatic void push_char(logic [7:0] b);
		pending_beats.push_back(item_t'{REQ_DATA, b});
		beats_queued++;
	endfunction

	function automatic void push_end();
		pending_beats.push_back(item_t'{REQ_END, 8'($urandom_range(255))});
		beats_queued++;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i]);
	endfunction

	function automatic void flush_line();
		foreach (line_buf[i]) push_char(line_buf[i]);
		line_buf.delete();
	endfunction

	function automatic void add_digits(int n);
		for (int i = 0; i < n; i++) line_buf.push_back(CH_0 + 8'($urandom_range(9)));
	endfunction

	// any byte that does not end a column or a line
	function automatic void add_plain(int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			do b = 8'($urandom_range(255));
			while (b == CH_COMMA || b == CH_CR || b == CH_LF);
			line_buf.push_back(b);
		end
	endfunction

	// mostly short numbers, now and then long enough to wrap 64 bits
	function automatic int field_len();
		return ($urandom_range(9) == 0) ? $urandom_range(22, 12) : $urandom_range(5);
	endfunction

	function automatic void add_decimal();
		add_digits(field_len());
		if ($urandom_range(1) == 1) begin
			line_buf.push_back(CH_DOT);
			add_digits(($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(8));
		end
		line_buf.push_back(CH_COMMA);
	endfunction

	function automatic logic [7:0] side_char(bit bad);
		logic [7:0] b;
		if (!bad) begin
			case ($urandom_range(5))
				0: b = CH_T_LC;
				1: b = CH_T_UC;
				2: b = CH_1;
				3: b = CH_F_LC;
				4: b = CH_F_UC;
				default: b = CH_0;
			endcase
		end else begin
			do b = 8'($urandom_range(255));
			while (b inside {CH_T_LC, CH_T_UC, CH_1, CH_F_LC, CH_F_UC, CH_0});
		end
		return b;
	endfunction

	function automatic void build_record(bit bad_side);
		line_buf.delete();
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(2))
				0: line_buf.push_back(CH_LF);
				1: begin
					line_buf.push_back(CH_CR);
					line_buf.push_back(CH_LF);
				end
				default: line_buf.push_back(CH_CR);
			endcase
		end
		add_digits(field_len());
		line_buf.push_back(CH_COMMA);
		add_decimal();
		add_decimal();
		add_plain($urandom_range(4));
		line_buf.push_back(CH_COMMA);
		add_digits(field_len());
		line_buf.push_back(CH_COMMA);
		line_buf.push_back(side_char(bad_side));
		add_plain($urandom_range(3));
		line_buf.push_back(CH_COMMA);
		add_plain($urandom_range(4));
		if ($urandom_range(1) == 1) line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
	endfunction

	task automatic gen_traffic(int unsigned beats);
		int unsigned target;
		int unsigned kind;
		int unsigned cut;
		target = beats_queued + beats;
		while (beats_queued < target) begin
			kind = $urandom_range(99);
			build_record(kind >= 84 && kind < 90);
			if (kind < 74) begin
				flush_line();
				if ($urandom_range(9) == 0) push_end();
			end else if (kind < 84) begin
				line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
				flush_line();
				push_end();
			end else if (kind < 90) begin
				flush_line();
				push_end();
			end else if (kind < 96) begin
				// cut short, so the end beat lands in any column
				cut = $urandom_range(line_buf.size() - 1);
				while (line_buf.size() > cut) void'(line_buf.pop_back());
				flush_line();
				push_end();
			end else begin
				line_buf.delete();
				repeat ($urandom_range(6, 1)) line_buf.push_back(8'($urandom_range(255)));
				flush_line();
				push_end();
			end
		end
	endtask

	task automatic drain();
		while (pending_beats.size() != 0 || item_valid) @(posedge clk);
		while (expected_records.size() != 0) @(posedge clk);
	endtask

	// driver: a beat stays on the port until it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) parse_char(char_beat);
			if (!item_valid || item_ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					char_beat <= pending_beats.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) check_record(parsed);
			if (hold_armed && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("csv_trade_record_parser verification failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		clear_line();
		halted = 0;

		push_text("\r\n\n\r");
		push_text(",.,9.123456789,,,T,\r\n");
		push_char(8'hff);
		push_end();
		push_char(8'h00);
		push_end();
		push_text(",,,,,x");
		push_end();
		push_text(",,,,,");
		push_end();
		push_text(",,,,,1,,");
		push_end();
		push_text(",,,,,0,\r0");
		push_end();
		push_text("1,2,3,,4,F,q");
		push_end();
		push_end();
		push_text("5,6.7.8");
		push_end();
		push_text(",,,\n");
		push_end();

		gen_traffic(600);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		send_idle_pct <= 81;
		recv_idle_pct <= 32;
		gen_traffic(600);
		drain();

		// no idling, and one long result stall while beats keep coming
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		hold_armed <= 1'b1;
		gen_traffic(600);
		drain();

		repeat (8) @(posedge clk);
		if (bad_records == 0) begin
			$display("csv_trade_record_parser verification clean");
		end else begin
			$display("csv_trade_record_parser verification failed");
		end
		$finish;
	end

endmodule
